@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, request codes, controller states and the command and status
// bundles passed between the scheduler controller and datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_JOBS  = 16;
  localparam int JOB_IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  localparam int REQ_W  = 2;
  localparam int SLOT_W = 4;
  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int CNT_W  = 5;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;

  typedef logic [JOB_IDX_W-1:0] job_idx_t;
  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [ARR_W-1:0]     arr_t;
  typedef logic [BUR_W-1:0]     bur_t;
  typedef logic [PRI_W-1:0]     pri_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [SUM_W-1:0]     sum_t;

  localparam req_t REQ_LOAD    = 2'd0;
  localparam req_t REQ_TICK    = 2'd1;
  localparam req_t REQ_RESTART = 2'd2;

  localparam time_t  TIME_MAX  = '1;
  localparam sum_t   SUM_MAX   = '1;
  localparam count_t COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SWEEP,
    ST_SCAN,
    ST_UPDATE,
    ST_TAT,
    ST_WT,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic write_slot;
    logic sweep;
    logic scan;
    logic update;
    logic calc_tat;
    logic calc_wt;
    logic accumulate;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic sweep_last;
    logic found;
    logic finishing;
  } dp_status_t;

endpackage

@@ rtl/pps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for the scheduler: takes one item at a time, steps the datapath
// through table write, restart sweep or slot scan and result arithmetic, and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pps_pkg::req_t      req_type,
  output logic               out_valid,
  input  logic               out_stall,
  input  pps_pkg::dp_status_t status,
  output pps_pkg::ctrl_cmd_t cmd
);

  pps_pkg::state_t state;
  pps_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != pps_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (req_type)
            pps_pkg::REQ_LOAD:    state_next = pps_pkg::ST_WRITE;
            pps_pkg::REQ_TICK:    state_next = pps_pkg::ST_SCAN;
            pps_pkg::REQ_RESTART: state_next = pps_pkg::ST_SWEEP;
            default:              state_next = pps_pkg::ST_DONE;
          endcase
        end
      end
      pps_pkg::ST_WRITE:  state_next = pps_pkg::ST_DONE;
      pps_pkg::ST_SWEEP: begin
        if (status.sweep_last) state_next = pps_pkg::ST_DONE;
      end
      pps_pkg::ST_SCAN: begin
        if (status.scan_last) state_next = pps_pkg::ST_UPDATE;
      end
      pps_pkg::ST_UPDATE: begin
        // only a completing job needs the time arithmetic
        if (status.found && status.finishing) state_next = pps_pkg::ST_TAT;
        else state_next = pps_pkg::ST_DONE;
      end
      pps_pkg::ST_TAT:    state_next = pps_pkg::ST_WT;
      pps_pkg::ST_WT:     state_next = pps_pkg::ST_ACC;
      pps_pkg::ST_ACC:    state_next = pps_pkg::ST_DONE;
      pps_pkg::ST_DONE: begin
        if (out_free) state_next = pps_pkg::ST_IDLE;
      end
      default:            state_next = pps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      pps_pkg::ST_IDLE:   cmd.accept     = in_valid;
      pps_pkg::ST_WRITE:  cmd.write_slot = 1'b1;
      pps_pkg::ST_SWEEP:  cmd.sweep      = 1'b1;
      pps_pkg::ST_SCAN:   cmd.scan       = 1'b1;
      pps_pkg::ST_UPDATE: cmd.update     = 1'b1;
      pps_pkg::ST_TAT:    cmd.calc_tat   = 1'b1;
      pps_pkg::ST_WT:     cmd.calc_wt    = 1'b1;
      pps_pkg::ST_ACC:    cmd.accumulate = 1'b1;
      pps_pkg::ST_DONE:   cmd.out_load   = out_free;
      default:            cmd            = '0;
    endcase
  end

  // hold the result until taken; a fresh load replaces a taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/pps_datapath.sv @@
// ----------------------------------------------------------------------------
// pps_datapath
// Job tables, scan comparator, time counters, running sums and the output
// register of the scheduler. Driven step by step from the controller.
// ----------------------------------------------------------------------------
module pps_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pps_pkg::ctrl_cmd_t  cmd,
  output pps_pkg::dp_status_t status,
  input  logic                cfg_wr_en,
  input  pps_pkg::count_t     cfg_wr_data,
  input  pps_pkg::slot_t      slot,
  input  pps_pkg::arr_t       arrival_time,
  input  pps_pkg::bur_t       burst_time,
  input  pps_pkg::pri_t       priority_req,
  output logic                ran_idle,
  output pps_pkg::slot_t      ran_slot,
  output logic                slot_finished,
  output pps_pkg::time_t      finish_time,
  output pps_pkg::time_t      turnaround,
  output pps_pkg::time_t      waiting,
  output pps_pkg::sum_t       total_waiting,
  output pps_pkg::sum_t       total_turnaround,
  output logic                all_done,
  output pps_pkg::time_t      current_time
);

  pps_pkg::arr_t   arrival_tab   [pps_pkg::MAX_JOBS];
  pps_pkg::bur_t   burst_tab     [pps_pkg::MAX_JOBS];
  pps_pkg::pri_t   prio_tab      [pps_pkg::MAX_JOBS];
  pps_pkg::bur_t   remaining_tab [pps_pkg::MAX_JOBS];

  pps_pkg::count_t process_count;
  pps_pkg::count_t n_eff;
  pps_pkg::count_t n_eff_next;

  pps_pkg::job_idx_t req_slot;
  logic              req_slot_ok;
  pps_pkg::arr_t     req_arr;
  pps_pkg::bur_t     req_bur;
  pps_pkg::pri_t     req_pri;

  pps_pkg::job_idx_t idx;
  logic              found;
  pps_pkg::job_idx_t best_idx;
  pps_pkg::pri_t     best_pri;
  pps_pkg::arr_t     best_arr;
  pps_pkg::bur_t     best_bur;
  pps_pkg::bur_t     best_rem;

  pps_pkg::time_t  tick_counter;
  pps_pkg::count_t finished_count;
  pps_pkg::sum_t   waiting_sum;
  pps_pkg::sum_t   turnaround_sum;

  logic            res_idle;
  pps_pkg::slot_t  res_slot;
  logic            res_fin;
  pps_pkg::time_t  res_ftime;
  pps_pkg::time_t  res_tat;
  pps_pkg::time_t  res_wt;
  pps_pkg::time_t  res_now;

  pps_pkg::arr_t   cand_arr;
  pps_pkg::pri_t   cand_pri;
  pps_pkg::bur_t   cand_rem;
  logic            cand_ready;
  logic            cand_better;
  logic            idx_active;

  logic [pps_pkg::SUM_W:0] wsum_add;
  logic [pps_pkg::SUM_W:0] tsum_add;

  // effective job count: zero reads as one, clamp to the table size
  always_comb begin
    if (process_count == '0) begin
      n_eff_next = pps_pkg::count_t'(1);
    end else if (32'(process_count) > pps_pkg::MAX_JOBS) begin
      n_eff_next = pps_pkg::count_t'(pps_pkg::MAX_JOBS);
    end else begin
      n_eff_next = process_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= pps_pkg::count_t'(1);
    end else if (cfg_wr_en) begin
      process_count <= cfg_wr_data;
    end
  end

  assign cand_arr    = arrival_tab[idx];
  assign cand_pri    = prio_tab[idx];
  assign cand_rem    = remaining_tab[idx];
  assign cand_ready  = (cand_rem != '0) &&
                       (pps_pkg::time_t'(cand_arr) <= res_now);
  // strict compares keep the lower slot on a full tie
  assign cand_better = !found || (cand_pri > best_pri) ||
                       ((cand_pri == best_pri) && (cand_arr < best_arr));
  assign idx_active  = (32'(idx) < 32'(n_eff));

  assign status.scan_last  = (32'(idx) + 1 >= 32'(n_eff));
  assign status.sweep_last = (32'(idx) == pps_pkg::MAX_JOBS - 1);
  assign status.found      = found;
  assign status.finishing  = (best_rem == pps_pkg::bur_t'(1));

  assign wsum_add = {1'b0, waiting_sum} + (pps_pkg::SUM_W+1)'(res_wt);
  assign tsum_add = {1'b0, turnaround_sum} + (pps_pkg::SUM_W+1)'(res_tat);

  // job tables without reset
  always_ff @(posedge clk) begin
    if (cmd.write_slot && req_slot_ok) begin
      arrival_tab[req_slot] <= req_arr;
      burst_tab[req_slot]   <= req_bur;
      prio_tab[req_slot]    <= req_pri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pps_pkg::MAX_JOBS; i++) begin
        remaining_tab[i] <= '0;
      end
    end else if (cmd.write_slot && req_slot_ok) begin
      remaining_tab[req_slot] <= req_bur;
    end else if (cmd.sweep) begin
      remaining_tab[idx] <= idx_active ? burst_tab[idx] : '0;
    end else if (cmd.update && found) begin
      remaining_tab[best_idx] <= best_rem - pps_pkg::bur_t'(1);
    end
  end

  // item capture, scan and result arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_slot    <= pps_pkg::job_idx_t'(slot);
      req_slot_ok <= (32'(slot) < pps_pkg::MAX_JOBS);
      req_arr     <= arrival_time;
      req_bur     <= burst_time;
      req_pri     <= priority_req;
      n_eff       <= n_eff_next;
      idx         <= '0;
      found       <= 1'b0;
      best_idx    <= '0;
      res_idle    <= 1'b0;
      res_slot    <= '0;
      res_fin     <= 1'b0;
      res_ftime   <= '0;
      res_tat     <= '0;
      res_wt      <= '0;
      res_now     <= tick_counter;
    end
    if (cmd.sweep) begin
      idx     <= idx + pps_pkg::job_idx_t'(1);
      res_now <= '0;
    end
    if (cmd.scan) begin
      idx <= idx + pps_pkg::job_idx_t'(1);
      if (cand_ready && cand_better) begin
        found    <= 1'b1;
        best_idx <= idx;
        best_pri <= cand_pri;
        best_arr <= cand_arr;
        best_bur <= burst_tab[idx];
        best_rem <= cand_rem;
      end
    end
    if (cmd.update) begin
      res_idle <= !found;
      res_slot <= pps_pkg::slot_t'(best_idx);
      res_fin  <= found && status.finishing;
      if (found && status.finishing) begin
        res_ftime <= (res_now == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX
                                                    : res_now + pps_pkg::time_t'(1);
      end
    end
    if (cmd.calc_tat) begin
      res_tat <= res_ftime - pps_pkg::time_t'(best_arr);
    end
    if (cmd.calc_wt) begin
      res_wt <= (res_tat > pps_pkg::time_t'(best_bur))
                ? res_tat - pps_pkg::time_t'(best_bur) : '0;
    end
  end

  // run counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter   <= '0;
      finished_count <= '0;
      waiting_sum    <= '0;
      turnaround_sum <= '0;
    end else if (cmd.sweep) begin
      tick_counter   <= '0;
      finished_count <= '0;
      waiting_sum    <= '0;
      turnaround_sum <= '0;
    end else if (cmd.update) begin
      if (tick_counter != pps_pkg::TIME_MAX) begin
        tick_counter <= tick_counter + pps_pkg::time_t'(1);
      end
    end else if (cmd.accumulate) begin
      if (finished_count != pps_pkg::COUNT_MAX) begin
        finished_count <= finished_count + pps_pkg::count_t'(1);
      end
      waiting_sum    <= wsum_add[pps_pkg::SUM_W] ? pps_pkg::SUM_MAX
                                                 : wsum_add[pps_pkg::SUM_W-1:0];
      turnaround_sum <= tsum_add[pps_pkg::SUM_W] ? pps_pkg::SUM_MAX
                                                 : tsum_add[pps_pkg::SUM_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ran_idle         <= res_idle;
      ran_slot         <= res_slot;
      slot_finished    <= res_fin;
      finish_time      <= res_ftime;
      turnaround       <= res_tat;
      waiting          <= res_wt;
      total_waiting    <= waiting_sum;
      total_turnaround <= turnaround_sum;
      all_done         <= (finished_count >= n_eff);
      current_time     <= res_now;
    end
  end

endmodule

@@ rtl/preemptive_priority_scheduler.sv @@
// A load writes one table slot and an unused request code goes straight to the
// result. A restart sweeps all MAX_JOBS slots; a tick scans the active jobs, one a
// cycle, updates the chosen one and, when it completes, adds its times to the sums.
// One item at a time: taken the cycle after the result is registered.
// Reset (rst, synchronous): remaining work, tick, count and sums cleared,
// process_count set to 1; arrival, burst and priority tables undefined.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Tick-driven preemptive priority scheduler over a table of jobs: controller
// plus datapath.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  pps_pkg::count_t     cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pps_pkg::req_t       req_type,
  input  pps_pkg::slot_t      slot,
  input  pps_pkg::arr_t       arrival_time,
  input  pps_pkg::bur_t       burst_time,
  input  pps_pkg::pri_t       priority_req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                ran_idle,
  output pps_pkg::slot_t      ran_slot,
  output logic                slot_finished,
  output pps_pkg::time_t      finish_time,
  output pps_pkg::time_t      turnaround,
  output pps_pkg::time_t      waiting,
  output pps_pkg::sum_t       total_waiting,
  output pps_pkg::sum_t       total_turnaround,
  output logic                all_done,
  output pps_pkg::time_t      current_time
);

  pps_pkg::ctrl_cmd_t  cmd;
  pps_pkg::dp_status_t status;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pps_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .slot             (slot),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .priority_req     (priority_req),
    .ran_idle         (ran_idle),
    .ran_slot         (ran_slot),
    .slot_finished    (slot_finished),
    .finish_time      (finish_time),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .total_waiting    (total_waiting),
    .total_turnaround (total_turnaround),
    .all_done         (all_done),
    .current_time     (current_time)
  );

endmodule

@@ rtl/pps_checker.sv @@
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks on the scheduler's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic             ran_idle,
  input pps_pkg::slot_t   ran_slot,
  input logic             slot_finished,
  input pps_pkg::time_t   finish_time,
  input pps_pkg::time_t   waiting,
  input pps_pkg::time_t   turnaround,
  input pps_pkg::sum_t    total_waiting,
  input pps_pkg::sum_t    total_turnaround,
  input pps_pkg::time_t   current_time
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result present straight after reset");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && ran_idle |-> !slot_finished && (ran_slot == '0))
    else $error("idle tick reports a job");

  a_finish_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_finished |->
      (finish_time == current_time + pps_pkg::time_t'(1)) ||
      ((current_time == pps_pkg::TIME_MAX) && (finish_time == pps_pkg::TIME_MAX)))
    else $error("finish time not one past the tick");

  a_sums_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_turnaround >= total_waiting) &&
                  (!slot_finished || (turnaround >= waiting)))
    else $error("waiting exceeds turnaround");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

@@ tb/preemptive_priority_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb
// Self-checking bench for the tick-driven priority scheduler. A short table
// of directed items covers reset, the extremes, restart and preemption. After
// it come randomised scheduling runs: set the slot count, load every
// participating slot, restart, then tick to completion with stray loads,
// restarts and unused request codes mixed in. Each report is checked against
// the table or an in-bench model, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam req_t REQ_UNUSED   = 2'd3;
  localparam int   DIRECTED_LEN = 21;
  localparam int   RANDOM_ITEMS = 1500;
  localparam int   CYCLE_LIMIT  = 500000;

  typedef struct packed {
    req_t  req;
    slot_t slot;
    arr_t  arr;
    bur_t  bur;
    pri_t  pri;
  } sched_item_t;

  typedef struct packed {
    logic   idle;
    slot_t  slot;
    logic   fin;
    time_t  ftime;
    time_t  tat;
    time_t  wt;
    sum_t   twait;
    sum_t   ttat;
    logic   done;
    time_t  now;
  } sched_report_t;

  typedef struct packed {
    logic          set_cfg;
    count_t        cfg_val;
    sched_item_t   item;
    logic          typed;
    sched_report_t want;
  } directed_row_t;

  localparam sched_item_t TICK_ITEM    = '{REQ_TICK, '0, '0, '0, '0};
  localparam sched_item_t RESTART_ITEM = '{REQ_RESTART, '0, '0, '0, '0};
  localparam sched_item_t UNUSED_ITEM  = '{REQ_UNUSED, '0, '0, '0, '0};

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_wr_en = 1'b0;
  count_t cfg_wr_data = '0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  req_t   req_type = REQ_LOAD;
  slot_t  slot = '0;
  arr_t   arrival_time = '0;
  bur_t   burst_time = '0;
  pri_t   priority_req = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   ran_idle;
  slot_t  ran_slot;
  logic   slot_finished;
  time_t  finish_time;
  time_t  turnaround;
  time_t  waiting;
  sum_t   total_waiting;
  sum_t   total_turnaround;
  logic   all_done;
  time_t  current_time;

  preemptive_priority_scheduler dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .slot             (slot),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .priority_req     (priority_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .ran_idle         (ran_idle),
    .ran_slot         (ran_slot),
    .slot_finished    (slot_finished),
    .finish_time      (finish_time),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .total_waiting    (total_waiting),
    .total_turnaround (total_turnaround),
    .all_done         (all_done),
    .current_time     (current_time)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Scheduler state as the bench sees it
  arr_t   job_arrival [MAX_JOBS] = '{default: '0};
  bur_t   job_burst   [MAX_JOBS] = '{default: '0};
  bur_t   job_left    [MAX_JOBS] = '{default: '0};
  pri_t   job_prio    [MAX_JOBS] = '{default: '0};
  time_t  clock_tick = '0;
  count_t done_count = '0;
  sum_t   wait_total = '0;
  sum_t   tat_total  = '0;
  count_t slots_cfg  = 5'd1;

  sched_report_t report_q [$];
  bit quiet = 1'b0;
  bit last_all_done = 1'b0;
  int mismatches = 0;
  int items_sent = 0;
  int ticks_run = 0;
  int jobs_done = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  directed_row_t directed_rows [DIRECTED_LEN] = '{
    // fresh from reset: idle tick, unused code, one job of two units
    '{1'b1, 5'd1, TICK_ITEM, 1'b1,
      '{1'b1, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 25'd0, 25'd0, 1'b0, 21'd0}},
    '{1'b0, 5'd0, UNUSED_ITEM, 1'b1,
      '{1'b0, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 25'd0, 25'd0, 1'b0, 21'd1}},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd0, 16'd0, 16'd2, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 25'd0, 25'd0, 1'b0, 21'd1}},
    '{1'b0, 5'd0, TICK_ITEM, 1'b1,
      '{1'b0, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 25'd0, 25'd0, 1'b0, 21'd1}},
    '{1'b0, 5'd0, TICK_ITEM, 1'b1,
      '{1'b0, 4'd0, 1'b1, 21'd3, 21'd3, 21'd1, 25'd1, 25'd3, 1'b1, 21'd2}},
    '{1'b0, 5'd0, RESTART_ITEM, 1'b1,
      '{1'b0, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 25'd0, 25'd0, 1'b0, 21'd0}},
    // field extremes outside the active range, then a job with no work
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 25'd0, 25'd0, 1'b0, 21'd0}},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 25'd0, 25'd0, 1'b0, 21'd0}},
    '{1'b0, 5'd0, TICK_ITEM, 1'b1,
      '{1'b1, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 25'd0, 25'd0, 1'b0, 21'd0}},
    // three jobs: earlier arrival breaks a priority tie, slot 1 preempts
    '{1'b1, 5'd3, '{REQ_LOAD, 4'd0, 16'd1, 16'd3, 8'd5}, 1'b0, '0},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd1, 16'd2, 16'd2, 8'd9}, 1'b0, '0},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd2, 16'd0, 16'd2, 8'd5}, 1'b0, '0},
    '{1'b0, 5'd0, RESTART_ITEM, 1'b0, '0},
    '{1'b0, 5'd0, TICK_ITEM, 1'b0, '0},
    '{1'b0, 5'd0, TICK_ITEM, 1'b0, '0},
    '{1'b0, 5'd0, TICK_ITEM, 1'b0, '0},
    '{1'b0, 5'd0, TICK_ITEM, 1'b0, '0},
    '{1'b0, 5'd0, TICK_ITEM, 1'b0, '0},
    '{1'b0, 5'd0, TICK_ITEM, 1'b0, '0},
    '{1'b0, 5'd0, TICK_ITEM, 1'b0, '0},
    '{1'b0, 5'd0, TICK_ITEM, 1'b0, '0}
  };

  function automatic int unsigned active_count();
    if (slots_cfg == 0) return 1;
    if (slots_cfg > MAX_JOBS) return MAX_JOBS;
    return slots_cfg;
  endfunction

  function automatic sum_t sat_sum(sum_t a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > SUM_MAX) ? SUM_MAX : sum_t'(s);
  endfunction

  // Apply one item to the bench state and return the report it should give
  function automatic sched_report_t schedule_step(sched_item_t it);
    sched_report_t r;
    int unsigned n;
    int best;
    bit found;
    int unsigned ft, ta, wt;
    r = '0;
    n = active_count();
    best = 0;
    found = 1'b0;
    r.now = clock_tick;
    case (it.req)
      REQ_LOAD: begin
        job_arrival[it.slot] = it.arr;
        job_burst[it.slot]   = it.bur;
        job_prio[it.slot]    = it.pri;
        job_left[it.slot]    = it.bur;
      end
      REQ_RESTART: begin
        clock_tick = '0;
        done_count = '0;
        wait_total = '0;
        tat_total  = '0;
        for (int i = 0; i < MAX_JOBS; i++) job_left[i] = (i < n) ? job_burst[i] : '0;
        r.now = '0;
      end
      REQ_TICK: begin
        for (int i = 0; i < n; i++) begin
          if (job_left[i] == 0 || job_arrival[i] > clock_tick) continue;
          if (!found || job_prio[i] > job_prio[best] ||
              (job_prio[i] == job_prio[best] && job_arrival[i] < job_arrival[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.idle = 1'b1;
        end else begin
          r.slot = slot_t'(best);
          job_left[best] = job_left[best] - 1'b1;
          if (job_left[best] == 0) begin
            ft = (clock_tick == TIME_MAX) ? TIME_MAX : clock_tick + 1;
            ta = ft - job_arrival[best];
            wt = (ta > job_burst[best]) ? ta - job_burst[best] : 0;
            r.fin   = 1'b1;
            r.ftime = time_t'(ft);
            r.tat   = time_t'(ta);
            r.wt    = time_t'(wt);
            if (done_count != COUNT_MAX) done_count++;
            wait_total = sat_sum(wait_total, wt);
            tat_total  = sat_sum(tat_total, ta);
          end
        end
        if (clock_tick != TIME_MAX) clock_tick++;
      end
      default: ;
    endcase
    r.twait = wait_total;
    r.ttat  = tat_total;
    r.done  = (done_count >= n);
    return r;
  endfunction

  function automatic sched_item_t random_job(slot_t s);
    sched_item_t j;
    j.req  = REQ_LOAD;
    j.slot = s;
    j.arr  = ($urandom_range(0, 15) == 0) ? arr_t'($urandom) : arr_t'($urandom_range(0, 12));
    j.bur  = ($urandom_range(0, 39) == 0) ? bur_t'($urandom_range(1, 65535))
                                          : bur_t'($urandom_range(1, 6));
    j.pri  = $urandom_range(0, 1) ? pri_t'($urandom_range(0, 3)) : pri_t'($urandom);
    return j;
  endfunction

  task automatic drive_item(sched_item_t it, bit typed, sched_report_t want);
    int gap;
    sched_report_t pred;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= it.req;
    slot         <= it.slot;
    arrival_time <= it.arr;
    burst_time   <= it.bur;
    priority_req <= it.pri;
    do @(posedge clk); while (in_stall);
    pred = schedule_step(it);
    report_q.push_back(typed ? want : pred);
    last_all_done = pred.done;
    items_sent++;
    if (it.req == REQ_TICK) ticks_run++;
    if (pred.fin) jobs_done++;
  endtask

  // Drop valid, let every report come home, then allow the longest tail
  task automatic drain_block();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_count(count_t v);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slots_cfg = v;
    cfg_writes++;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin : report_check
    int hold;
    sched_report_t got, want;
    do @(posedge clk); while (rst);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 9);
      out_stall <= (hold != 0);
      do @(posedge clk); while (!out_valid);
      if (hold != 0) begin
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end
      got = '{ran_idle, ran_slot, slot_finished, finish_time, turnaround, waiting,
              total_waiting, total_turnaround, all_done, current_time};
      if (report_q.size() == 0) begin
        mismatches++;
        $display("%0t: report with nothing outstanding, expected none, got %h", $time, got);
      end else begin
        want = report_q.pop_front();
        check_field("ran_idle", want.idle, got.idle);
        check_field("ran_slot", want.slot, got.slot);
        check_field("slot_finished", want.fin, got.fin);
        check_field("finish_time", want.ftime, got.ftime);
        check_field("turnaround", want.tat, got.tat);
        check_field("waiting", want.wt, got.wt);
        check_field("total_waiting", want.twait, got.twait);
        check_field("total_turnaround", want.ttat, got.ttat);
        check_field("all_done", want.done, got.done);
        check_field("current_time", want.now, got.now);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d reports outstanding",
               cycle_count, report_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int tail;
    int steps;
    int pick;
    count_t cfg;
    sched_item_t it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].set_cfg) write_count(directed_rows[k].cfg_val);
      drive_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    end

    // Each phase is one scheduling run: load, restart, tick until all finish or 120 steps
    phase = 0;
    while (items_sent < DIRECTED_LEN + RANDOM_ITEMS) begin
      phase++;
      case (phase)
        1: cfg = 5'd0;
        2: cfg = 5'd31;
        3: cfg = 5'd16;
        4: cfg = 5'd17;
        default: cfg = ($urandom_range(0, 3) == 0) ? count_t'($urandom_range(0, 31))
                                                   : count_t'($urandom_range(1, 8));
      endcase
      write_count(cfg);
      quiet = (phase % 4 == 3);
      for (int s = 0; s < active_count(); s++) drive_item(random_job(slot_t'(s)), 1'b0, '0);
      drive_item(RESTART_ITEM, 1'b0, '0);
      tail  = 3;
      steps = 0;
      while (tail > 0 && steps < 120) begin
        pick = $urandom_range(0, 99);
        it = random_job(slot_t'($urandom_range(0, 15)));
        if (pick < 82) begin
          it.req = REQ_TICK;
        end else if (pick < 94) begin
          it.req = REQ_LOAD;
        end else if (pick < 97) begin
          it.req = REQ_UNUSED;
          it.arr = arr_t'($urandom);
          it.bur = bur_t'($urandom);
          it.pri = pri_t'($urandom);
        end else begin
          it.req = REQ_RESTART;
        end
        drive_item(it, 1'b0, '0);
        if (last_all_done) tail--;
        steps++;
      end
    end

    quiet = 1'b0;
    drain_block();
    repeat (40) @(posedge clk);
    $display("Sent %0d items over %0d slot-count settings: %0d ticks, %0d jobs completed.",
             items_sent, cfg_writes, ticks_run, jobs_done);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
